// ----- design/dual_width_alu_register_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef DUAL_WIDTH_ALU_REGISTER_UNIT_MACROS_SVH
`define DUAL_WIDTH_ALU_REGISTER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DWA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DWA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/dwa_pkg.sv -----
// Shared types, operation codes and flag positions for the register unit.
package dwa_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0, OP_SBC = 6'd1, OP_AND = 6'd2, OP_ORA = 6'd3, OP_EOR = 6'd4,
    OP_CMP = 6'd5, OP_CPX = 6'd6, OP_CPY = 6'd7, OP_BIT = 6'd8, OP_LDA = 6'd9,
    OP_LDX = 6'd10, OP_LDY = 6'd11, OP_STA = 6'd12, OP_STX = 6'd13, OP_STY = 6'd14,
    OP_STZ = 6'd15, OP_ASL = 6'd16, OP_LSR = 6'd17, OP_ROL = 6'd18, OP_ROR = 6'd19,
    OP_INC = 6'd20, OP_DEC = 6'd21, OP_TSB = 6'd22, OP_TRB = 6'd23, OP_INA = 6'd24,
    OP_DEA = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27, OP_DEX = 6'd28, OP_DEY = 6'd29,
    OP_TAX = 6'd30, OP_TAY = 6'd31, OP_TCD = 6'd32, OP_TCS = 6'd33, OP_TDC = 6'd34,
    OP_TSC = 6'd35, OP_TSX = 6'd36, OP_TXA = 6'd37, OP_TXS = 6'd38, OP_TXY = 6'd39,
    OP_TYA = 6'd40, OP_TYX = 6'd41, OP_SEC = 6'd42, OP_SED = 6'd43, OP_SEI = 6'd44,
    OP_CLC = 6'd45, OP_CLI = 6'd46, OP_CLD = 6'd47, OP_CLV = 6'd48, OP_REP = 6'd49,
    OP_SEP = 6'd50, OP_XBA = 6'd51, OP_XCE = 6'd52
  } op_e;

  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagM = 5;
  localparam int unsigned FlagX = 4;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [15:0] SpReset = 16'h01FF;
  localparam logic [7:0] StatusReset = 8'h34;
  localparam logic [7:0] SpPage = 8'h01;

  typedef struct packed {
    logic [5:0] func;
    logic [15:0] operand;
  } req_t;

  typedef struct packed {
    logic [15:0] acc_out;
    logic [15:0] x_out;
    logic [15:0] y_out;
    logic [15:0] sp_out;
    logic [15:0] dp_out;
    logic [7:0] status_out;
    logic emul_out;
    logic mem_write;
    logic [15:0] mem_data;
  } rsp_t;

  // Architectural register set.
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0] p;
    logic e;
  } regs_t;

endpackage

// ----- design/dwa_exec.sv -----
// Combinational execute logic: next register state and write-back for one request.
module dwa_exec (
  input  logic [5:0]         func_i,
  input  logic [15:0]        operand_i,
  input  dwa_pkg::regs_t     cur_i,
  output dwa_pkg::regs_t     nxt_o,
  output logic               wr_o,
  output logic [15:0]        wdata_o
);
  import dwa_pkg::*;

  logic        m8, x8, cin;
  logic [15:0] mm, xm, sgn, a, v, vx, r, ix, iy;
  logic [16:0] sum;
  logic [15:0] bop;
  regs_t       n;
  logic        fix;

  // Set N and Z of a value at a given width mask.
  function automatic logic [7:0] nz(input logic [7:0] p, input logic [15:0] val,
                                    input logic w8);
    logic [7:0] q;
    q = p;
    q[FlagN] = w8 ? val[7] : val[15];
    q[FlagZ] = w8 ? (val[7:0] == 8'h00) : (val == 16'h0000);
    return q;
  endfunction

  assign m8  = cur_i.p[FlagM];
  assign x8  = cur_i.p[FlagX];
  assign cin = cur_i.p[FlagC];
  assign mm  = m8 ? 16'h00FF : 16'hFFFF;
  assign xm  = x8 ? 16'h00FF : 16'hFFFF;
  assign sgn = m8 ? 16'h0080 : 16'h8000;
  assign a   = cur_i.a & mm;
  assign v   = operand_i & mm;
  assign vx  = operand_i & xm;
  assign ix  = cur_i.x & xm;
  assign iy  = cur_i.y & xm;

  // Shared adder for ADC and SBC.
  assign bop = (func_i == OP_SBC) ? (~v & mm) : v;
  assign sum = {1'b0, a} + {1'b0, bop} + {16'd0, cin};

  always_comb begin
    n   = cur_i;
    r   = '0;
    wr_o = 1'b0;
    fix = 1'b0;
    case (func_i)
      OP_ADC, OP_SBC: begin
        r = sum[15:0] & mm;
        n.a = m8 ? {cur_i.a[15:8], r[7:0]} : r;
        n.p[FlagC] = m8 ? sum[8] : sum[16];
        n.p[FlagV] = |(~(a ^ bop) & (a ^ sum[15:0]) & sgn);
        n.p = nz(n.p, r, m8);
        r = '0;
      end
      OP_AND, OP_ORA, OP_EOR, OP_LDA: begin
        case (func_i)
          OP_AND:  r = a & v;
          OP_ORA:  r = a | v;
          OP_EOR:  r = a ^ v;
          default: r = v;
        endcase
        n.a = m8 ? {cur_i.a[15:8], r[7:0]} : r;
        n.p = nz(n.p, r, m8);
        r = '0;
      end
      OP_CMP: begin
        n.p = nz(n.p, (a - v) & mm, m8);
        n.p[FlagC] = a >= v;
      end
      OP_CPX: begin
        n.p = nz(n.p, (ix - vx) & xm, x8);
        n.p[FlagC] = ix >= vx;
      end
      OP_CPY: begin
        n.p = nz(n.p, (iy - vx) & xm, x8);
        n.p[FlagC] = iy >= vx;
      end
      OP_BIT: begin
        n.p[FlagN] = |(v & sgn);
        n.p[FlagV] = |(v & (sgn >> 1));
        n.p[FlagZ] = (a & v) == 16'h0000;
      end
      OP_LDX: begin n.x = vx; n.p = nz(n.p, vx, x8); end
      OP_LDY: begin n.y = vx; n.p = nz(n.p, vx, x8); end
      OP_STA: begin wr_o = 1'b1; r = a; end
      OP_STX: begin wr_o = 1'b1; r = ix; end
      OP_STY: begin wr_o = 1'b1; r = iy; end
      OP_STZ: begin wr_o = 1'b1; r = '0; end
      OP_ASL, OP_ROL: begin
        wr_o = 1'b1;
        r = ({v[14:0], (func_i == OP_ROL) ? cin : 1'b0}) & mm;
        n.p[FlagC] = |(v & sgn);
        n.p = nz(n.p, r, m8);
      end
      OP_LSR, OP_ROR: begin
        wr_o = 1'b1;
        r = (v >> 1) | (((func_i == OP_ROR) && cin) ? sgn : 16'h0000);
        n.p[FlagC] = v[0];
        n.p = nz(n.p, r, m8);
      end
      OP_INC: begin wr_o = 1'b1; r = (v + 16'd1) & mm; n.p = nz(n.p, r, m8); end
      OP_DEC: begin wr_o = 1'b1; r = (v - 16'd1) & mm; n.p = nz(n.p, r, m8); end
      OP_TSB: begin wr_o = 1'b1; n.p[FlagZ] = (a & v) == 16'h0000; r = v | a; end
      OP_TRB: begin wr_o = 1'b1; n.p[FlagZ] = (a & v) == 16'h0000; r = v & ~a & mm; end
      OP_INA, OP_DEA: begin
        r = ((func_i == OP_INA) ? (a + 16'd1) : (a - 16'd1)) & mm;
        n.a = m8 ? {cur_i.a[15:8], r[7:0]} : r;
        n.p = nz(n.p, r, m8);
        r = '0;
      end
      OP_INX: begin n.x = (cur_i.x + 16'd1) & xm; n.p = nz(n.p, n.x, x8); end
      OP_INY: begin n.y = (cur_i.y + 16'd1) & xm; n.p = nz(n.p, n.y, x8); end
      OP_DEX: begin n.x = (cur_i.x - 16'd1) & xm; n.p = nz(n.p, n.x, x8); end
      OP_DEY: begin n.y = (cur_i.y - 16'd1) & xm; n.p = nz(n.p, n.y, x8); end
      OP_TAX: begin n.x = cur_i.a & xm; n.p = nz(n.p, n.x, x8); end
      OP_TAY: begin n.y = cur_i.a & xm; n.p = nz(n.p, n.y, x8); end
      OP_TCD: begin n.dp = cur_i.a; n.p = nz(n.p, cur_i.a, 1'b0); end
      OP_TCS: n.sp = cur_i.e ? {SpPage, cur_i.a[7:0]} : cur_i.a;
      OP_TDC: begin n.a = cur_i.dp; n.p = nz(n.p, cur_i.dp, 1'b0); end
      OP_TSC: begin n.a = cur_i.sp; n.p = nz(n.p, cur_i.sp, 1'b0); end
      OP_TSX: begin n.x = cur_i.sp & xm; n.p = nz(n.p, n.x, x8); end
      OP_TXA: begin
        n.a = m8 ? {cur_i.a[15:8], cur_i.x[7:0]} : cur_i.x;
        n.p = nz(n.p, cur_i.x, m8);
      end
      OP_TXS: n.sp = cur_i.e ? {SpPage, cur_i.x[7:0]} : cur_i.x;
      OP_TXY: begin n.y = cur_i.x & xm; n.p = nz(n.p, n.y, x8); end
      OP_TYA: begin
        n.a = m8 ? {cur_i.a[15:8], cur_i.y[7:0]} : cur_i.y;
        n.p = nz(n.p, cur_i.y, m8);
      end
      OP_TYX: begin n.x = cur_i.y & xm; n.p = nz(n.p, n.x, x8); end
      OP_SEC: n.p[FlagC] = 1'b1;
      OP_SED: n.p[FlagD] = 1'b1;
      OP_SEI: n.p[FlagI] = 1'b1;
      OP_CLC: n.p[FlagC] = 1'b0;
      OP_CLI: n.p[FlagI] = 1'b0;
      OP_CLD: n.p[FlagD] = 1'b0;
      OP_CLV: n.p[FlagV] = 1'b0;
      OP_REP: begin n.p = cur_i.p & ~operand_i[7:0]; fix = 1'b1; end
      OP_SEP: begin n.p = cur_i.p | operand_i[7:0]; fix = 1'b1; end
      OP_XBA: begin
        n.a = {cur_i.a[7:0], cur_i.a[15:8]};
        n.p = nz(n.p, n.a, 1'b1);
      end
      OP_XCE: begin n.p[FlagC] = cur_i.e; n.e = cin; fix = 1'b1; end
      default: ;
    endcase
    // Mode fixups after REP, SEP and XCE.
    if (fix) begin
      if (n.e) begin
        n.p[FlagM] = 1'b1;
        n.p[FlagX] = 1'b1;
        n.sp = {SpPage, n.sp[7:0]};
      end
      if (n.p[FlagX]) begin
        n.x = {8'h00, n.x[7:0]};
        n.y = {8'h00, n.y[7:0]};
      end
    end
  end

  assign nxt_o   = n;
  assign wdata_o = wr_o ? r : 16'h0000;
endmodule

// ----- design/dual_width_alu_register_unit.sv -----
// Top level: input register, execute logic, architectural state and result register.
// Each request is executed from the input register; one request can be accepted every
// clock while in_stall_o is low. The result passes from the input register through the
// execute logic into the result register, where a stalled output holds it.
// The architectural registers are updated as a request leaves the input register,
// so back-to-back requests see each other's results without bubbles.
module dual_width_alu_register_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dwa_pkg::req_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dwa_pkg::rsp_t   out_data_o
);
  import dwa_pkg::*;

  logic   req_vld_q;
  req_t   req_q;
  regs_t  regs_q, regs_d;
  logic   wr;
  logic [15:0] wdata;
  logic   rsp_vld_q;
  rsp_t   rsp_q;
  logic   adv;

  // The pipeline moves whenever the result register is free or being drained.
  assign adv        = !rsp_vld_q || !out_stall_i;
  assign in_stall_o = req_vld_q && !adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  dwa_exec u_exec (
    .func_i   (req_q.func),
    .operand_i(req_q.operand),
    .cur_i    (regs_q),
    .nxt_o    (regs_d),
    .wr_o     (wr),
    .wdata_o  (wdata)
  );

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{a: 16'h0000, x: 16'h0000, y: 16'h0000, sp: SpReset,
                  dp: 16'h0000, p: StatusReset, e: 1'b1};
    end else if (req_vld_q && adv) begin
      regs_q <= regs_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (adv) begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q && adv) begin
      rsp_q <= '{acc_out: regs_d.a, x_out: regs_d.x, y_out: regs_d.y,
                 sp_out: regs_d.sp, dp_out: regs_d.dp, status_out: regs_d.p,
                 emul_out: regs_d.e, mem_write: wr, mem_data: wdata};
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_data_o  = rsp_q;
endmodule

// ----- design/dwa_checker.sv -----
// Port-level checker for the register unit and its bind statement.
`include "dual_width_alu_register_unit_macros.svh"
module dwa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dwa_pkg::rsp_t out_data_o
);
  import dwa_pkg::*;

  `DWA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `DWA_ASSERT_IMP(a_wdata, clk_i, rst_ni, out_valid_o && !out_data_o.mem_write, out_data_o.mem_data == 16'h0000, "write data without write")
  `DWA_ASSERT_IMP(a_emul, clk_i, rst_ni, out_valid_o && out_data_o.emul_out, out_data_o.status_out[FlagM] && out_data_o.status_out[FlagX] && out_data_o.sp_out[15:8] == SpPage, "emulation mode state broken")
  `DWA_ASSERT_IMP(a_idx, clk_i, rst_ni, out_valid_o && out_data_o.status_out[FlagX], out_data_o.x_out[15:8] == 8'h00 && out_data_o.y_out[15:8] == 8'h00, "narrow index high byte set")
  `DWA_ASSERT_NXT(a_stall, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with no pending result")
endmodule

bind dual_width_alu_register_unit dwa_checker u_dwa_checker (.*);
